// File: sv/huffman_bit_packer_top_defines.svh
// huffman_bit_packer_top_defines.svh: assertion macros for the bit packer
// used by the modules that carry concurrent assertions; needs clock and reset in scope
`ifndef HUFFMAN_BIT_PACKER_TOP_DEFINES_SVH
`define HUFFMAN_BIT_PACKER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define HBP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hbp assertion failed");
// next-cycle implication, disabled during reset
`define HBP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hbp assertion failed");
`else
`define HBP_ASSERT_NOW(lbl, ante, cons)
`define HBP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: sv/hbp_pkg.sv
// hbp_pkg: shared types and constants of the huffman bit packer
// no dependencies
package hbp_pkg;

   // function codes of an input item
   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_ENCODE = 2'd1;
   localparam logic [1:0] FUNC_FLUSH  = 2'd2;

   localparam int CODE_W    = 32;
   localparam int LEN_W     = 6;
   localparam int PEND_W    = 7;
   localparam int PCNT_W    = 3;
   localparam int MAX_OUT   = 4;
   localparam int ACC_W     = 40;

   // one code table entry
   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] bits;
   } entry_type;

   // item held in the lookup stage
   typedef struct packed {
      logic       valid;
      logic [1:0] func;
      entry_type  entry;
   } stage_type;

endpackage

// File: sv/hbp_ram.sv
// hbp_ram: generic single-write, single-read RAM with registered read
// no dependencies
module hbp_ram #(
   parameter int WIDTH  = 38,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/hbp_table.sv
// hbp_table: code table (RAM plus per-entry valid bits) and the lookup stage register
// depends on hbp_pkg and hbp_ram
module hbp_table #(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               advance,
   input  logic [1:0]         func,
   input  logic [7:0]         symbol,
   input  logic [5:0]         code_length,
   input  logic [31:0]        code_bits,
   output hbp_pkg::stage_type stage
);

   localparam int ADDR_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int LIM_INT = (MAX_CODE_LEN < hbp_pkg::CODE_W) ? MAX_CODE_LEN : hbp_pkg::CODE_W;
   localparam logic [hbp_pkg::LEN_W-1:0] LIM_LEN = hbp_pkg::LEN_W'(LIM_INT);
   localparam logic [8:0] SYM_LIMIT = 9'(SYMBOL_COUNT);

   logic                       sym_ok;
   logic [ADDR_W-1:0]          addr;
   logic [hbp_pkg::LEN_W-1:0]  len_sat;
   logic [hbp_pkg::CODE_W:0]   bit_mask;
   hbp_pkg::entry_type         wr_entry;
   hbp_pkg::entry_type         rd_entry;
   logic                       wr_en;
   logic                       rd_en;
   logic [SYMBOL_COUNT-1:0]    valid_ff;
   logic [SYMBOL_COUNT-1:0]    valid_in;
   logic                       hit_ff;
   logic                       hit_in;
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic [1:0]                 s1_func_ff;

   // address decode and load entry shaping
   always_comb begin
      sym_ok   = ({1'b0, symbol} < SYM_LIMIT);
      addr     = symbol[ADDR_W-1:0];
      len_sat  = (code_length > LIM_LEN) ? LIM_LEN : code_length;
      bit_mask = ((hbp_pkg::CODE_W+1)'(1) << len_sat) - (hbp_pkg::CODE_W+1)'(1);
      wr_entry.len  = len_sat;
      wr_entry.bits = code_bits & bit_mask[hbp_pkg::CODE_W-1:0];
      wr_en = accept && sym_ok && (func == hbp_pkg::FUNC_LOAD);
      rd_en = accept;
   end

   hbp_ram #(
      .WIDTH ($bits(hbp_pkg::entry_type)),
      .DEPTH (SYMBOL_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (rd_entry)
   );

   // valid bits, lookup hit flag and stage occupancy
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[addr] = 1'b1;
      end
      hit_in = hit_ff;
      if (rd_en) begin
         hit_in = sym_ok && valid_ff[addr];
      end
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         hit_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         hit_ff      <= hit_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff <= func;
      end
   end

   // an entry never written reads as no code
   always_comb begin
      stage.valid = s1_valid_ff;
      stage.func  = s1_func_ff;
      stage.entry = hit_ff ? rd_entry : '0;
   end

endmodule

// File: sv/hbp_pack.sv
// hbp_pack: pending partial byte, bit packing and the result byte buffer
// depends on hbp_pkg and huffman_bit_packer_top_defines.svh
`include "huffman_bit_packer_top_defines.svh"
module hbp_pack (
   input  logic               clock,
   input  logic               reset,
   input  hbp_pkg::stage_type stage,
   output logic               advance,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last_of_run,
   output logic               rsp_padded
);

   logic [hbp_pkg::PEND_W-1:0] pbits_ff, pbits_in;
   logic [hbp_pkg::PCNT_W-1:0] pcnt_ff, pcnt_in;
   logic [7:0]                 bytes_ff [hbp_pkg::MAX_OUT];
   logic [7:0]                 bytes_in [hbp_pkg::MAX_OUT];
   logic [2:0]                 out_cnt_ff, out_cnt_in;
   logic [1:0]                 out_idx_ff, out_idx_in;
   logic                       pad_ff, pad_in;

   logic                       is_enc;
   logic                       is_fl;
   logic [hbp_pkg::LEN_W-1:0]  total;
   logic [hbp_pkg::ACC_W-1:0]  acc;
   logic [hbp_pkg::ACC_W-1:0]  aligned;
   logic [2:0]                 nres;
   logic [7:0]                 keep_mask;
   logic [7:0]                 flush_byte;
   logic [7:0]                 pend_mask;
   logic                       pop;
   logic                       buf_free;

   // packing datapath
   always_comb begin
      is_enc  = stage.valid && (stage.func == hbp_pkg::FUNC_ENCODE) &&
                (stage.entry.len != '0);
      is_fl   = stage.valid && (stage.func == hbp_pkg::FUNC_FLUSH) && (pcnt_ff != '0);
      total   = hbp_pkg::LEN_W'(pcnt_ff) + stage.entry.len;
      acc     = ((hbp_pkg::ACC_W)'(pbits_ff) << stage.entry.len) |
                (hbp_pkg::ACC_W)'(stage.entry.bits);
      aligned = acc << (hbp_pkg::LEN_W'(hbp_pkg::ACC_W) - total);
      keep_mask  = (8'd1 << total[2:0]) - 8'd1;
      flush_byte = {1'b0, pbits_ff} << (4'd8 - {1'b0, pcnt_ff});
      pend_mask  = (8'd1 << pcnt_ff) - 8'd1;
      if (is_enc) begin
         nres = total[5:3];
      end else if (is_fl) begin
         nres = 3'd1;
      end else begin
         nres = 3'd0;
      end
   end

   // handshake with the result side
   always_comb begin
      pop      = rsp_valid && !rsp_stall;
      buf_free = (out_cnt_ff == 3'd0) || ((out_cnt_ff == 3'd1) && pop);
      advance  = stage.valid && ((nres == 3'd0) || buf_free);
   end

   // next pending state and buffer contents
   always_comb begin
      pbits_in = pbits_ff;
      pcnt_in  = pcnt_ff;
      if (advance && is_enc) begin
         pcnt_in  = total[2:0];
         pbits_in = acc[hbp_pkg::PEND_W-1:0] & keep_mask[hbp_pkg::PEND_W-1:0];
      end else if (advance && is_fl) begin
         pcnt_in  = '0;
         pbits_in = '0;
      end
      bytes_in   = bytes_ff;
      out_cnt_in = out_cnt_ff;
      out_idx_in = out_idx_ff;
      pad_in     = pad_ff;
      if (advance && (nres != 3'd0)) begin
         for (int k = 0; k < hbp_pkg::MAX_OUT; k++) begin
            bytes_in[k] = aligned[hbp_pkg::ACC_W-1-8*k -: 8];
         end
         if (is_fl) begin
            bytes_in[0] = flush_byte;
         end
         out_cnt_in = nres;
         out_idx_in = 2'd0;
         pad_in     = is_fl;
      end else if (pop) begin
         out_cnt_in = out_cnt_ff - 3'd1;
         out_idx_in = out_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pbits_ff   <= '0;
         pcnt_ff    <= '0;
         out_cnt_ff <= '0;
         out_idx_ff <= '0;
      end else begin
         pbits_ff   <= pbits_in;
         pcnt_ff    <= pcnt_in;
         out_cnt_ff <= out_cnt_in;
         out_idx_ff <= out_idx_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      pad_ff   <= pad_in;
   end

   assign rsp_valid       = (out_cnt_ff != 3'd0);
   assign rsp_out_byte    = bytes_ff[out_idx_ff];
   assign rsp_last_of_run = (out_cnt_ff == 3'd1);
   assign rsp_padded      = pad_ff;

   // checks
   `HBP_ASSERT_NOW(a_cnt_range, 1'b1, out_cnt_ff <= 3'd4)
   `HBP_ASSERT_NOW(a_pend_clean, 1'b1, ({1'b0, pbits_ff} & ~pend_mask) == 8'd0)
   `HBP_ASSERT_NOW(a_pad_single, rsp_valid && rsp_padded, out_cnt_ff == 3'd1)
   `HBP_ASSERT_NEXT(a_idx_step, pop && (out_cnt_ff > 3'd1), out_idx_ff == $past(out_idx_ff) + 2'd1)

endmodule

// File: sv/huffman_bit_packer_top.sv
// huffman_bit_packer_top: huffman code table with msb-first bit packing
// depends on hbp_pkg, hbp_table, hbp_pack, hbp_ram
//
// Request channel (req_*): one item per transfer. req_func selects load of a
// code table entry, encode of req_symbol, or flush of the partial byte.
// Result channel (rsp_*): one packed byte per transfer, earliest bit in bit 7;
// rsp_last_of_run marks the final byte of an item, rsp_padded a flush byte.
// The first byte of an item is offered once its request transfer has passed
// the registered table read and the packing into the result buffer, and the
// lookup stage may wait on the buffer in between. Throughput: one item per
// cycle while each item yields at most one byte and rsp_stall is low. An item
// yielding N bytes holds the buffer until it drains, one byte per transfer;
// loads, empty flushes and codeless symbols yield nothing and never wait on it.
// Reset clears the pending bits and marks every table entry as having no code.
// While rsp_stall is high the offered byte holds; once the lookup stage is
// blocked behind the buffer, req_stall rises.
module huffman_bit_packer_top #(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_symbol,
   input  logic [5:0]  req_code_length,
   input  logic [31:0] req_code_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_padded
);

   hbp_pkg::stage_type stage;
   logic               advance;
   logic               accept;

   // request transfer
   assign req_stall = stage.valid && !advance;
   assign accept    = req_valid && !req_stall;

   hbp_table #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .advance     (advance),
      .func        (req_func),
      .symbol      (req_symbol),
      .code_length (req_code_length),
      .code_bits   (req_code_bits),
      .stage       (stage)
   );

   hbp_pack u_pack (
      .clock           (clock),
      .reset           (reset),
      .stage           (stage),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_padded      (rsp_padded)
   );

endmodule

// File: dv/tb_huffman_bit_packer_top.sv
// tb_huffman_bit_packer_top: self-checking bench for the huffman bit packer
// drives load, encode and flush requests and checks each packed byte in order
// depends on hbp_pkg and huffman_bit_packer_top
module tb_huffman_bit_packer_top;

   // the one function code that the package leaves unnamed
   localparam logic [1:0] FUNC_SPARE = 2'd3;
   localparam int MAX_LEN      = 32;
   localparam int SYMBOLS      = 256;
   localparam int WS_SIZE      = 16;
   localparam int RANDOM_ITEMS = 185;
   localparam int LONG_HOLD    = 80;
   localparam int IDLE_LIMIT   = 2000;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       padded;
   } packed_byte_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  symbol;
      logic [5:0]  code_length;
      logic [31:0] code_bits;
      logic [7:0]  gap;
      logic        hold_rx;
      logic        drain_first;
   } req_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = hbp_pkg::FUNC_LOAD;
   logic [7:0]  req_symbol = 8'h00;
   logic [5:0]  req_code_length = 6'd0;
   logic [31:0] req_code_bits = 32'h0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;
   logic        rsp_padded;

   // predictor state: code table and the partial byte
   logic [5:0]      code_len_tbl [SYMBOLS];
   logic [31:0]     code_word_tbl [SYMBOLS];
   logic [6:0]      carry_bits = 7'd0;
   logic [2:0]      carry_cnt = 3'd0;
   packed_byte_type expected_bytes [$];
   req_item_type    req_q [$];

   // bookkeeping
   int req_accepts = 0;
   int n_offered = 0;
   int cur_gap = 0;
   int gap_left = 0;
   int fail_count = 0;
   int bytes_checked = 0;
   int padded_seen = 0;
   int input_stall_cycles = 0;
   int func_hits [4] = '{0, 0, 0, 0};
   int idle_cycles = 0;

   // stimulus generator state
   logic [7:0] ws_sym [WS_SIZE];
   int  gen_left = 0;
   bit  gen_calm = 0;
   int  burst_left = 0;
   bit  mark_hold = 0;
   bit  mark_drain = 0;

   // receiver state
   logic rx_hold_token = 1'b0;
   logic rx_hold_seen = 1'b0;
   int   hold_left = 0;
   int   stall_left = 0;
   int   rx_phase_left = 0;
   bit   rx_calm = 0;
   bit   wind_down = 0;

   huffman_bit_packer_top #(
      .MAX_CODE_LEN(MAX_LEN),
      .SYMBOL_COUNT(SYMBOLS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_symbol(req_symbol),
      .req_code_length(req_code_length),
      .req_code_bits(req_code_bits),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_padded(rsp_padded)
   );

   always #6 clock = ~clock;

   function automatic logic [39:0] ones_below(input int n);
      if (n <= 0) return 40'd0;
      return (40'd1 << n) - 40'd1;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   // code lengths weighted towards short codes, with zero and oversize now and then
   function automatic logic [5:0] rand_code_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 6'($urandom_range(1, 8));
      if (r < 80) return 6'($urandom_range(9, 16));
      if (r < 93) return 6'($urandom_range(17, 32));
      if (r < 97) return 6'($urandom_range(33, 63));
      return 6'd0;
   endfunction

   // predicts the packed bytes of one accepted request
   task automatic pack_request(input logic [1:0] f, input logic [7:0] sym,
                               input logic [5:0] len, input logic [31:0] bits);
      int              lim;
      int              total;
      int              nbytes;
      logic [39:0]     acc;
      logic [39:0]     mask;
      packed_byte_type pb;
      case (f)
         hbp_pkg::FUNC_LOAD: begin
            lim = (int'(len) > MAX_LEN) ? MAX_LEN : int'(len);
            mask = ones_below(lim);
            code_len_tbl[sym] = 6'(lim);
            code_word_tbl[sym] = bits & mask[31:0];
         end
         hbp_pkg::FUNC_ENCODE: begin
            if (code_len_tbl[sym] != 6'd0) begin
               acc = (40'(carry_bits) << code_len_tbl[sym]) | 40'(code_word_tbl[sym]);
               total = int'(carry_cnt) + int'(code_len_tbl[sym]);
               nbytes = total / 8;
               for (int k = 0; k < nbytes; k++) begin
                  pb.out_byte = 8'(acc >> (total - 8 * (k + 1)));
                  pb.last_of_run = (k == nbytes - 1);
                  pb.padded = 1'b0;
                  expected_bytes.insert(expected_bytes.size(), pb);
               end
               carry_cnt = 3'(total % 8);
               mask = ones_below(int'(carry_cnt));
               carry_bits = 7'(acc & mask);
            end
         end
         hbp_pkg::FUNC_FLUSH: begin
            if (carry_cnt != 3'd0) begin
               pb.out_byte = {1'b0, carry_bits} << (8 - carry_cnt);
               pb.last_of_run = 1'b1;
               pb.padded = 1'b1;
               expected_bytes.insert(expected_bytes.size(), pb);
               carry_bits = 7'd0;
               carry_cnt = 3'd0;
            end
         end
         default: ;
      endcase
   endtask

   // queue one request with its trailing gap and any pressure marks
   task automatic add_req(input logic [1:0] f, input logic [7:0] sym,
                          input logic [5:0] len, input logic [31:0] bits);
      req_item_type it;
      it.func = f;
      it.symbol = sym;
      it.code_length = len;
      it.code_bits = bits;
      if (gen_left == 0) begin
         gen_calm = ($urandom_range(0, 3) == 0);
         gen_left = $urandom_range(10, 40);
      end else begin
         gen_left--;
      end
      if (burst_left > 0) begin
         burst_left--;
         it.gap = 8'd0;
      end else begin
         it.gap = gen_calm ? 8'd0 : 8'(pick_gap());
      end
      it.hold_rx = mark_hold;
      it.drain_first = mark_drain;
      if (mark_hold) burst_left = 30;
      mark_hold = 0;
      mark_drain = 0;
      req_q.insert(req_q.size(), it);
   endtask

   // stimulus and end of run
   initial begin
      int r;
      int pick;
      for (int s = 0; s < SYMBOLS; s++) begin
         code_len_tbl[s] = 6'd0;
         code_word_tbl[s] = 32'h0;
      end
      for (int w = 0; w < WS_SIZE; w++) ws_sym[w] = 8'($urandom_range(0, 255));
      ws_sym[0] = 8'h00;
      ws_sym[1] = 8'hFF;
      ws_sym[2] = 8'h20;

      // directed: empty table, empty flush, spare code, extremes and boundaries
      add_req(hbp_pkg::FUNC_ENCODE, 8'h41, 6'd0, 32'h0);
      add_req(hbp_pkg::FUNC_FLUSH, 8'h00, 6'd0, 32'h0);
      add_req(FUNC_SPARE, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
      add_req(hbp_pkg::FUNC_LOAD, 8'h00, 6'd1, 32'hFFFF_FFFF);
      add_req(hbp_pkg::FUNC_LOAD, 8'hFF, 6'd32, 32'hFFFF_FFFF);
      add_req(hbp_pkg::FUNC_LOAD, 8'h20, 6'd3, 32'h0000_0005);
      add_req(hbp_pkg::FUNC_LOAD, 8'h0A, 6'h3F, 32'hA5A5_5A5A);
      add_req(hbp_pkg::FUNC_LOAD, 8'h7F, 6'd7, 32'hFFFF_FFD5);
      add_req(hbp_pkg::FUNC_LOAD, 8'h80, 6'd33, 32'h1234_5678);
      add_req(hbp_pkg::FUNC_ENCODE, 8'h00, 6'd0, 32'h0);
      add_req(hbp_pkg::FUNC_ENCODE, 8'hFF, 6'd0, 32'h0);
      add_req(hbp_pkg::FUNC_ENCODE, 8'h0A, 6'd0, 32'h0);
      // code ends exactly on a byte boundary
      add_req(hbp_pkg::FUNC_ENCODE, 8'h7F, 6'd0, 32'h0);
      add_req(hbp_pkg::FUNC_FLUSH, 8'h00, 6'd0, 32'h0);
      // whitespace is encoded like any other byte
      add_req(hbp_pkg::FUNC_ENCODE, 8'h20, 6'd0, 32'h0);
      add_req(hbp_pkg::FUNC_FLUSH, 8'h00, 6'd0, 32'h0);
      // seven bits pending, then full-length codes
      add_req(hbp_pkg::FUNC_LOAD, 8'h02, 6'd7, 32'h0000_006B);
      add_req(hbp_pkg::FUNC_ENCODE, 8'h02, 6'd0, 32'h0);
      add_req(hbp_pkg::FUNC_ENCODE, 8'hFF, 6'd0, 32'h0);
      add_req(hbp_pkg::FUNC_ENCODE, 8'h80, 6'd0, 32'h0);
      add_req(hbp_pkg::FUNC_FLUSH, 8'h00, 6'd0, 32'h0);
      // a cleared entry emits nothing
      add_req(hbp_pkg::FUNC_LOAD, 8'h00, 6'd0, 32'hFFFF_FFFF);
      add_req(hbp_pkg::FUNC_ENCODE, 8'h00, 6'd0, 32'h0);
      add_req(hbp_pkg::FUNC_ENCODE, 8'h20, 6'd0, 32'h0);
      add_req(FUNC_SPARE, 8'h00, 6'd0, 32'h0);

      // random: load a working set, then mostly encodes with some noise
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 60 || i == 140) mark_hold = 1;
         if (i == 100 || i == 170) mark_drain = 1;
         pick = $urandom_range(0, WS_SIZE - 1);
         r = $urandom_range(0, 99);
         if (i < WS_SIZE)
            add_req(hbp_pkg::FUNC_LOAD, ws_sym[i], rand_code_len(), $urandom);
         else if (r < 12)
            add_req(hbp_pkg::FUNC_LOAD, ws_sym[pick], rand_code_len(), $urandom);
         else if (r < 75)
            add_req(hbp_pkg::FUNC_ENCODE, ws_sym[pick], 6'($urandom), $urandom);
         else if (r < 87)
            add_req(hbp_pkg::FUNC_FLUSH, 8'($urandom), 6'($urandom), $urandom);
         else if (r < 94)
            add_req(hbp_pkg::FUNC_ENCODE, 8'($urandom), 6'($urandom), $urandom);
         else
            add_req(FUNC_SPARE, 8'($urandom), 6'($urandom), $urandom);
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_q.size() != 0 || req_valid || expected_bytes.size() != 0)
         @(posedge clock);
      wind_down = 1;
      repeat (12) @(posedge clock);
      fail_count += expected_bytes.size();

      $display("covered %0d requests: %0d loads, %0d encodes, %0d flushes, %0d spare",
               req_accepts, func_hits[hbp_pkg::FUNC_LOAD], func_hits[hbp_pkg::FUNC_ENCODE],
               func_hits[hbp_pkg::FUNC_FLUSH], func_hits[FUNC_SPARE]);
      $display("checked %0d bytes (%0d padded), input held off for %0d cycles",
               bytes_checked, padded_seen, input_stall_cycles);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // request driver: new item only after the previous transfer and its gap
   always @(negedge clock) begin
      logic         nv;
      int           gl;
      req_item_type it;
      if (!reset) begin
         nv = req_valid;
         gl = gap_left;
         if (req_valid && req_accepts == n_offered) begin
            nv = 1'b0;
            gl = cur_gap;
         end
         if (!nv) begin
            if (gl > 0) begin
               gl--;
            end else if (req_q.size() != 0 &&
                         !(req_q[0].drain_first && expected_bytes.size() != 0)) begin
               it = req_q.pop_front();
               req_func <= it.func;
               req_symbol <= it.symbol;
               req_code_length <= it.code_length;
               req_code_bits <= it.code_bits;
               cur_gap = int'(it.gap);
               n_offered++;
               if (it.hold_rx) rx_hold_token <= ~rx_hold_token;
               nv = 1'b1;
            end
         end
         req_valid <= nv;
         gap_left = gl;
      end
   end

   // result receiver: random stalls, calm stretches and the long hold
   always @(negedge clock) begin
      logic ns;
      if (!reset) begin
         if (rx_hold_token != rx_hold_seen) begin
            rx_hold_seen = rx_hold_token;
            hold_left = LONG_HOLD;
         end
         if (rx_phase_left == 0) begin
            rx_calm = ($urandom_range(0, 3) == 0);
            rx_phase_left = $urandom_range(20, 80);
         end else begin
            rx_phase_left--;
         end
         if (wind_down) begin
            ns = 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            ns = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            ns = 1'b1;
         end else begin
            ns = 1'b0;
            stall_left = rx_calm ? 0 : pick_gap();
         end
         rsp_stall <= ns;
      end
   end

   // monitor: predict on each request transfer, check each result transfer
   always @(posedge clock) begin
      packed_byte_type exp_b;
      if (!reset) begin
         if (req_valid && req_stall) input_stall_cycles++;
         if (req_valid && !req_stall) begin
            req_accepts++;
            func_hits[req_func]++;
            pack_request(req_func, req_symbol, req_code_length, req_code_bits);
         end
         if (rsp_valid && !rsp_stall) begin
            bytes_checked++;
            if (rsp_padded === 1'b1) padded_seen++;
            if (expected_bytes.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("unexpected byte %02h last %b padded %b",
                           rsp_out_byte, rsp_last_of_run, rsp_padded);
            end else begin
               exp_b = expected_bytes.pop_front();
               if (rsp_out_byte !== exp_b.out_byte ||
                   rsp_last_of_run !== exp_b.last_of_run ||
                   rsp_padded !== exp_b.padded) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX)
                     $display("mismatch on byte %0d: expected %02h/%b/%b, got %02h/%b/%b",
                              bytes_checked, exp_b.out_byte, exp_b.last_of_run,
                              exp_b.padded, rsp_out_byte, rsp_last_of_run, rsp_padded);
               end
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("no transfer for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

endmodule
